/* rtl/base37_name_decoder_core_macros.svh */
// Assertion macros shared by the base-37 name decoder RTL.
`ifndef BASE37_NAME_DECODER_CORE_MACROS_SVH
`define BASE37_NAME_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define B37ND_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define B37ND_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define B37ND_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define B37ND_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

/* rtl/b37nd_pkg.sv */
// Shared types, constants and helper functions of the base-37 name decoder.
package b37nd_pkg;

  localparam int NAME_W        = 64;
  localparam int CHAR_W        = 7;
  localparam int DIGIT_W       = 6;
  localparam int MAX_CHARS_DEF = 12;
  localparam int RADIX         = 37;

  // Long division by the radix works on 16-bit chunks of the quotient.
  localparam int CHUNK_W     = 16;
  localparam int DIV_X_W     = DIGIT_W + CHUNK_W;
  // Reciprocal: 2^28 / 37, rounded upward; exact for every dividend below 2^22.
  localparam int RECIP_W     = 23;
  localparam int RECIP_SHIFT = 28;
  localparam logic [RECIP_W-1:0] RECIP = 23'd7255013;

  // Result of one chunk step of the divider.
  typedef struct packed {
    logic [CHUNK_W-1:0] quo;
    logic [DIGIT_W-1:0] rem;
  } div_result_t;

  // Largest name value plus one: 37 to the power of the name length.
  function automatic logic [NAME_W-1:0] name_limit(input int nchars);
    logic [NAME_W-1:0] lim;
    lim = {{(NAME_W-1){1'b0}}, 1'b1};
    for (int i = 0; i < nchars; i++) begin
      lim = lim * NAME_W'(RADIX);
    end
    return lim;
  endfunction

  // Map one base-37 digit to its ASCII character.
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d == '0) begin
      c = 7'd95;                          // underscore
    end else if (d <= 6'd26) begin
      c = 7'(d) + 7'd96;                  // 'a' .. 'z'
    end else if (d <= 6'd36) begin
      c = 7'(d) + 7'd21;                  // '0' .. '9'
    end else begin
      c = '0;
    end
    return c;
  endfunction

endpackage

/* rtl/b37nd_ram.sv */
// Generic single-port-write, registered-read RAM.
module b37nd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/b37nd_div_step.sv */
// One long-division step by 37: remainder plus a 16-bit chunk in, quotient chunk out.
module b37nd_div_step (
  input  logic [b37nd_pkg::DIGIT_W-1:0] rem_in,
  input  logic [b37nd_pkg::CHUNK_W-1:0] chunk,
  output b37nd_pkg::div_result_t        res
);

  import b37nd_pkg::*;

  localparam int PROD_W = DIV_X_W + RECIP_W;

  logic [DIV_X_W-1:0] x;
  logic [PROD_W-1:0]  prod;
  logic [CHUNK_W-1:0] quo;
  logic [DIV_X_W-1:0] back;
  logic [DIV_X_W-1:0] diff;

  // Form the partial dividend and scale by the reciprocal of 37
  assign x    = {rem_in, chunk};
  assign prod = PROD_W'(x) * PROD_W'(RECIP);
  assign quo  = prod[RECIP_SHIFT +: CHUNK_W];

  // Recover the remainder from the quotient chunk
  assign back = DIV_X_W'(quo) * DIV_X_W'(RADIX);
  assign diff = x - back;

  assign res.quo = quo;
  assign res.rem = diff[DIGIT_W-1:0];

endmodule

/* rtl/base37_name_decoder_core.sv */
// Top level of the base-37 name decoder: sequencer, divider, digit buffer, result register.
//
//  channel  | signals                                  | transfer
//  ---------+------------------------------------------+----------------------------------
//  input    | start, packed_name, busy                 | start high while busy is low
//  result   | char_strobe, char_code, last_char,       | every cycle char_strobe is high
//           | invalid                                  |
//
// A rejected value (not positive or too large) gives its invalid result in the cycle
// after the transfer and leaves busy low. Otherwise the shared divide-by-37 unit works
// through each digit one 16-bit chunk a cycle. The characters then come out one per
// cycle, the last one in the first cycle after busy falls. A value divisible by 37 is
// caught after the first digit and gives an invalid result. Reset (rst, synchronous)
// returns the sequencer to idle; the result side has no stall, so each result is shown
// for exactly one cycle.
module base37_name_decoder_core #(
  parameter int MAX_CHARS = b37nd_pkg::MAX_CHARS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic signed [b37nd_pkg::NAME_W-1:0] packed_name,
  output logic                              busy,
  output logic                              char_strobe,
  output logic [b37nd_pkg::CHAR_W-1:0]      char_code,
  output logic                              last_char,
  output logic                              invalid
);

  import b37nd_pkg::*;

  `include "base37_name_decoder_core_macros.svh"

  localparam int AW    = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int CW    = $clog2(MAX_CHARS + 1);
  localparam int STEPS = NAME_W / CHUNK_W;
  localparam int SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam logic [NAME_W-1:0] LIMIT     = name_limit(MAX_CHARS);
  localparam logic [SW-1:0]     LAST_STEP = SW'(STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_LOAD = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t             state;
  logic [NAME_W-1:0]  quotient_reg;
  logic [CW-1:0]      digit_count;
  logic [SW-1:0]      step;
  logic [DIGIT_W-1:0] rem;
  logic [AW-1:0]      idx;

  logic               accept;
  logic               bad_value;
  logic [DIGIT_W-1:0] rem_in;
  div_result_t        div_res;
  logic [NAME_W-1:0]  quotient_next;
  logic               last_step;
  logic               trailing_zero;
  logic [CW-1:0]      count_m1;
  logic               wr_en;
  logic [AW-1:0]      rd_addr;
  logic [DIGIT_W-1:0] rd_digit;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Range check on the incoming value
  assign bad_value = packed_name[NAME_W-1] || (packed_name == '0) ||
                     ($unsigned(packed_name) >= LIMIT);

  // Shared divider: feed the top chunk, remainder cleared at each new digit
  assign rem_in = (step == '0) ? '0 : rem;

  b37nd_div_step u_div (
    .rem_in (rem_in),
    .chunk  (quotient_reg[NAME_W-1 -: CHUNK_W]),
    .res    (div_res)
  );

  assign quotient_next = {quotient_reg[NAME_W-CHUNK_W-1:0], div_res.quo};
  assign last_step     = (state == S_DIV) && (step == LAST_STEP);
  assign trailing_zero = (digit_count == '0) && (div_res.rem == '0);
  assign count_m1      = digit_count - CW'(1);

  // Digit buffer: write each digit, read back most significant first
  assign wr_en   = last_step && !trailing_zero;
  assign rd_addr = (state == S_LOAD) ? count_m1[AW-1:0] : (idx - AW'(1));

  b37nd_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (MAX_CHARS)
  ) u_digits (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (digit_count[AW-1:0]),
    .wr_data (div_res.rem),
    .rd_addr (rd_addr),
    .rd_data (rd_digit)
  );

  // Sequencer and working registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      quotient_reg <= '0;
      digit_count  <= '0;
      step         <= '0;
      rem          <= '0;
      idx          <= '0;
      char_strobe  <= 1'b0;
    end else begin
      char_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            step        <= '0;
            digit_count <= '0;
            if (bad_value) begin
              quotient_reg <= '0;
              char_strobe  <= 1'b1;
            end else begin
              quotient_reg <= $unsigned(packed_name);
              state        <= S_DIV;
            end
          end
        end
        S_DIV: begin
          quotient_reg <= quotient_next;
          rem          <= div_res.rem;
          step         <= step + SW'(1);
          if (last_step) begin
            if (trailing_zero) begin
              quotient_reg <= '0;
              digit_count  <= '0;
              char_strobe  <= 1'b1;
              state        <= S_IDLE;
            end else begin
              digit_count <= digit_count + CW'(1);
              if (quotient_next == '0) begin
                state <= S_LOAD;
              end
            end
          end
        end
        S_LOAD: begin
          idx   <= count_m1[AW-1:0];
          state <= S_EMIT;
        end
        S_EMIT: begin
          char_strobe <= 1'b1;
          idx         <= idx - AW'(1);
          if (idx == '0) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    case (state)
      S_EMIT: begin
        char_code <= digit_to_ascii(rd_digit);
        last_char <= (idx == '0);
        invalid   <= 1'b0;
      end
      default: begin
        char_code <= '0;
        last_char <= 1'b1;
        invalid   <= 1'b1;
      end
    endcase
  end

  `B37ND_ASSERT_IMP(a_invalid_form, clk, rst, char_strobe && invalid,
    last_char && (char_code == '0), "invalid result must be a lone zero character")

  `B37ND_ASSERT_NXT(a_accept_outcome, clk, rst, accept,
    busy || (char_strobe && invalid), "accepted value neither started nor rejected")

  `B37ND_ASSERT_IMP(a_char_from_work, clk, rst, char_strobe && !invalid,
    $past(busy), "name character emitted while idle")

endmodule
